FILE: design/jrpt_pkg.sv
// ----------------------------------------------------------------------------
// jrpt_pkg: shared types and constants for the joint repetition phase tracker
// Angles are signed tenths of a degree, twelve bits wide.
// ----------------------------------------------------------------------------
package jrpt_pkg;

    localparam int ANGLE_W     = 12;
    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_W     = 17;
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [COUNT_WIDTH-1:0]    count_t;

    typedef enum logic [1:0] {
        PH_STANDING = 2'd0,
        PH_RISING   = 2'd1,
        PH_HOLDING  = 2'd2,
        PH_FALLING  = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_THRESHOLD    = 3'd0,
        CFG_UPPER_THRESHOLD    = 3'd1,
        CFG_FIRST_WINDOW_LOW   = 3'd2,
        CFG_FIRST_WINDOW_HIGH  = 3'd3,
        CFG_SECOND_WINDOW_LOW  = 3'd4,
        CFG_SECOND_WINDOW_HIGH = 3'd5
    } cfg_index_t;

    localparam angle_t RST_LOWER_THRESHOLD    = 12'sd300;
    localparam angle_t RST_UPPER_THRESHOLD    = 12'sd900;
    localparam angle_t RST_FIRST_WINDOW_LOW   = 12'sd700;
    localparam angle_t RST_FIRST_WINDOW_HIGH  = 12'sd1000;
    localparam angle_t RST_SECOND_WINDOW_LOW  = 12'sd800;
    localparam angle_t RST_SECOND_WINDOW_HIGH = 12'sd1100;

    typedef struct packed {
        angle_t main_angle;
        angle_t aux_angle_one;
        angle_t aux_angle_two;
    } in_t;

    typedef struct packed {
        phase_t               phase;
        angle_t               peak_angle;
        logic [TOTAL_W-1:0]   fail_total;
        logic                 warning;
        logic                 capture_begin;
        logic                 capture_end;
        logic                 started;
    } out_t;

    typedef struct packed {
        angle_t lower_threshold;
        angle_t upper_threshold;
        angle_t first_window_low;
        angle_t first_window_high;
        angle_t second_window_low;
        angle_t second_window_high;
    } cfg_t;

endpackage

FILE: design/jrpt_cfg_regs.sv
// ----------------------------------------------------------------------------
// jrpt_cfg_regs: threshold and window register file
// Written through a plain write port; indexes past the last register are dropped.
// ----------------------------------------------------------------------------
module jrpt_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [jrpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jrpt_pkg::ANGLE_W-1:0]      cfg_data,
    output jrpt_pkg::cfg_t                    cfg
);

    jrpt_pkg::cfg_t cfg_reg;
    jrpt_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                jrpt_pkg::CFG_LOWER_THRESHOLD:    cfg_next.lower_threshold    = cfg_data;
                jrpt_pkg::CFG_UPPER_THRESHOLD:    cfg_next.upper_threshold    = cfg_data;
                jrpt_pkg::CFG_FIRST_WINDOW_LOW:   cfg_next.first_window_low   = cfg_data;
                jrpt_pkg::CFG_FIRST_WINDOW_HIGH:  cfg_next.first_window_high  = cfg_data;
                jrpt_pkg::CFG_SECOND_WINDOW_LOW:  cfg_next.second_window_low  = cfg_data;
                jrpt_pkg::CFG_SECOND_WINDOW_HIGH: cfg_next.second_window_high = cfg_data;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_threshold    <= jrpt_pkg::RST_LOWER_THRESHOLD;
            cfg_reg.upper_threshold    <= jrpt_pkg::RST_UPPER_THRESHOLD;
            cfg_reg.first_window_low   <= jrpt_pkg::RST_FIRST_WINDOW_LOW;
            cfg_reg.first_window_high  <= jrpt_pkg::RST_FIRST_WINDOW_HIGH;
            cfg_reg.second_window_low  <= jrpt_pkg::RST_SECOND_WINDOW_LOW;
            cfg_reg.second_window_high <= jrpt_pkg::RST_SECOND_WINDOW_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/jrpt_core.sv
// ----------------------------------------------------------------------------
// jrpt_core: phase machine, peak tracker and saturating fail counters
// Computes one result from the registered sample and commits state on step.
// ----------------------------------------------------------------------------
module jrpt_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  jrpt_pkg::in_t   sample,
    input  jrpt_pkg::cfg_t  cfg,
    output jrpt_pkg::out_t  result
);

    localparam int SUM_W  = jrpt_pkg::COUNT_WIDTH + 1;
    localparam int WIDE_W = (SUM_W > jrpt_pkg::TOTAL_W) ? SUM_W : jrpt_pkg::TOTAL_W;

    jrpt_pkg::phase_t  phase_reg,   phase_next;
    logic              started_reg, started_next;
    jrpt_pkg::angle_t  peak_reg,    peak_next;
    jrpt_pkg::count_t  count_one_reg, count_one_next;
    jrpt_pkg::count_t  count_two_reg, count_two_next;

    logic              fail_one;
    logic              fail_two;
    logic              begin_flag;
    logic              end_flag;
    logic [WIDE_W-1:0] total_wide;

    always_comb
    begin
        phase_next     = phase_reg;
        started_next   = started_reg | (sample.main_angle > 12'sd0);
        peak_next      = peak_reg;
        count_one_next = count_one_reg;
        count_two_next = count_two_reg;
        begin_flag     = 1'b0;
        end_flag       = 1'b0;

        fail_one = (sample.aux_angle_one < cfg.first_window_low) ||
                   (sample.aux_angle_one > cfg.first_window_high);
        fail_two = (sample.aux_angle_two < cfg.second_window_low) ||
                   (sample.aux_angle_two > cfg.second_window_high);

        if (started_next)
        begin
            if (fail_one && (count_one_reg != '1))
                count_one_next = count_one_reg + jrpt_pkg::count_t'(1);
            if (fail_two && (count_two_reg != '1))
                count_two_next = count_two_reg + jrpt_pkg::count_t'(1);
            if (sample.main_angle > peak_reg)
                peak_next = sample.main_angle;

            case (phase_reg)
                jrpt_pkg::PH_STANDING:
                begin
                    peak_next      = '0;
                    count_one_next = '0;
                    count_two_next = '0;
                    if (sample.main_angle > cfg.lower_threshold)
                    begin
                        phase_next = jrpt_pkg::PH_RISING;
                        begin_flag = 1'b1;
                    end
                end
                jrpt_pkg::PH_RISING:
                begin
                    if (sample.main_angle >= cfg.upper_threshold)
                        phase_next = jrpt_pkg::PH_HOLDING;
                    else if (sample.main_angle <= cfg.lower_threshold)
                        phase_next = jrpt_pkg::PH_STANDING;
                end
                jrpt_pkg::PH_HOLDING:
                begin
                    if (sample.main_angle < cfg.upper_threshold)
                        phase_next = jrpt_pkg::PH_FALLING;
                end
                default:
                begin
                    if (sample.main_angle <= cfg.lower_threshold)
                    begin
                        phase_next = jrpt_pkg::PH_STANDING;
                        end_flag   = 1'b1;
                    end
                end
            endcase
        end

        total_wide = WIDE_W'(count_one_next) + WIDE_W'(count_two_next);

        result.phase         = phase_next;
        result.peak_angle    = peak_next;
        result.fail_total    = total_wide[jrpt_pkg::TOTAL_W-1:0];
        result.warning       = started_next & fail_two;
        result.capture_begin = begin_flag;
        result.capture_end   = end_flag;
        result.started       = started_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jrpt_pkg::PH_STANDING;
            started_reg   <= 1'b0;
            peak_reg      <= '0;
            count_one_reg <= '0;
            count_two_reg <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            peak_reg      <= peak_next;
            count_one_reg <= count_one_next;
            count_two_reg <= count_two_next;
        end
    end

endmodule

FILE: design/joint_rep_phase_tracker.sv
// ----------------------------------------------------------------------------
// joint_rep_phase_tracker: repetition phase tracker for joint angle samples
// Input register, single-pass phase/peak/counter logic, result register.
// ----------------------------------------------------------------------------
// A sample waits in the input register until a core step registers its result.
// Throughput: one sample per cycle, set by the core state update, unless stalled.
// A waiting result does not block intake; the input register keeps taking items
// until both registers hold data and the output is stalled.
// Reset: asynchronous, active low; phase standing, peak and counters zero,
// thresholds and windows back to their defaults, both stages empty.
module joint_rep_phase_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  jrpt_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output jrpt_pkg::out_t                  out_data,
    input  logic                            cfg_write,
    input  logic [jrpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jrpt_pkg::ANGLE_W-1:0]    cfg_data
);

    logic           in_valid_reg;
    jrpt_pkg::in_t  in_data_reg;
    logic           out_valid_reg;
    jrpt_pkg::out_t out_data_reg;

    jrpt_pkg::cfg_t cfg;
    jrpt_pkg::out_t result;
    logic           advance;
    logic           take_in;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    jrpt_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jrpt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: design/jrpt_checker.sv
// ----------------------------------------------------------------------------
// jrpt_checker: port-level checks for the joint repetition phase tracker
// Bound to the top level; looks only at its ports.
// ----------------------------------------------------------------------------
module jrpt_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  jrpt_pkg::out_t                  out_data
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // before the first positive main angle nothing moves
    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.started |->
            out_data.phase == jrpt_pkg::PH_STANDING && out_data.peak_angle == '0 &&
            out_data.fail_total == '0 && !out_data.warning &&
            !out_data.capture_begin && !out_data.capture_end)
        else $error("activity reported before start");

    a_begin_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.capture_begin |->
            out_data.phase == jrpt_pkg::PH_RISING && !out_data.capture_end &&
            out_data.peak_angle == '0 && out_data.fail_total == '0)
        else $error("capture begin with wrong state");

    a_end_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.capture_end |->
            out_data.phase == jrpt_pkg::PH_STANDING && out_data.started)
        else $error("capture end without standing");

    // started is sticky across transactions
    a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.started |=> !out_valid || out_data.started)
        else $error("started flag dropped");

endmodule

bind joint_rep_phase_tracker jrpt_checker u_jrpt_checker (.*);

FILE: test/joint_rep_phase_tracker_test.sv
// ----------------------------------------------------------------------------
// joint_rep_phase_tracker_test: self-checking bench for the phase tracker
// Drives samples through the valid/stall input channel with random gaps,
// stalls the result channel at random, and checks every result field
// against an in-bench tracker model. Covers the wait for a positive main
// angle, full repetitions, crossed and extreme register settings, a long
// stay in rising, and random sessions under several register settings.
// ----------------------------------------------------------------------------
module joint_rep_phase_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WAIT      = 14;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SESSION_ITEMS = 120;
    localparam int NUM_SESSIONS  = 8;
    localparam int PARK_ITEMS    = 40;

    // indexes past the last register; writes there must be ignored
    localparam logic [jrpt_pkg::CFG_IDX_W-1:0] CFG_SPARE_LOW  = 3'd6;
    localparam logic [jrpt_pkg::CFG_IDX_W-1:0] CFG_SPARE_HIGH = 3'd7;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    jrpt_pkg::in_t                  in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    jrpt_pkg::out_t                 out_data;
    logic                           cfg_write = 1'b0;
    logic [jrpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [jrpt_pkg::ANGLE_W-1:0]   cfg_data  = '0;

    // tracker model state
    jrpt_pkg::angle_t lim [0:5] = '{jrpt_pkg::RST_LOWER_THRESHOLD,
                                    jrpt_pkg::RST_UPPER_THRESHOLD,
                                    jrpt_pkg::RST_FIRST_WINDOW_LOW,
                                    jrpt_pkg::RST_FIRST_WINDOW_HIGH,
                                    jrpt_pkg::RST_SECOND_WINDOW_LOW,
                                    jrpt_pkg::RST_SECOND_WINDOW_HIGH};
    jrpt_pkg::phase_t trk_phase   = jrpt_pkg::PH_STANDING;
    logic             trk_started = 1'b0;
    jrpt_pkg::angle_t trk_peak    = '0;
    jrpt_pkg::count_t cnt_one     = '0;
    jrpt_pkg::count_t cnt_two     = '0;

    jrpt_pkg::out_t expected_reports [$];
    int   mismatches  = 0;
    int   sent_count  = 0;
    int   rx_hold     = 0;
    int   idle_cycles = 0;
    bit   tx_calm     = 1'b0;
    bit   rx_calm     = 1'b0;

    joint_rep_phase_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(MAX_WAIT));
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic jrpt_pkg::angle_t clamp_angle(int v);
        if (v > 1800)
            v = 1800;
        if (v < -1800)
            v = -1800;
        return jrpt_pkg::angle_t'(v);
    endfunction

    function automatic jrpt_pkg::in_t make_sample(int m, int a1, int a2);
        jrpt_pkg::in_t s;
        s.main_angle    = clamp_angle(m);
        s.aux_angle_one = clamp_angle(a1);
        s.aux_angle_two = clamp_angle(a2);
        return s;
    endfunction

    // mostly hugs the window edges, sometimes anywhere in range
    function automatic int near_window(jrpt_pkg::angle_t lo, jrpt_pkg::angle_t hi);
        int span;
        span = (int'(hi) >= int'(lo)) ? int'(hi) - int'(lo) : 0;
        if ($urandom_range(4) == 0)
            return rand_between(-1800, 1800);
        return int'(lo) - 40 + int'($urandom_range(span + 80));
    endfunction

    // one tracker step: counts, peak, phase advance; returns the report
    function automatic jrpt_pkg::out_t track_step(jrpt_pkg::in_t s);
        jrpt_pkg::out_t r;
        logic warn;
        logic cap_begin;
        logic cap_end;
        warn      = 1'b0;
        cap_begin = 1'b0;
        cap_end   = 1'b0;
        if (s.main_angle > 0)
            trk_started = 1'b1;
        if (trk_started)
        begin
            if (s.aux_angle_one < lim[jrpt_pkg::CFG_FIRST_WINDOW_LOW] ||
                s.aux_angle_one > lim[jrpt_pkg::CFG_FIRST_WINDOW_HIGH])
            begin
                if (cnt_one != '1)
                    cnt_one++;
            end
            if (s.aux_angle_two < lim[jrpt_pkg::CFG_SECOND_WINDOW_LOW] ||
                s.aux_angle_two > lim[jrpt_pkg::CFG_SECOND_WINDOW_HIGH])
            begin
                if (cnt_two != '1)
                    cnt_two++;
                warn = 1'b1;
            end
            if (s.main_angle > trk_peak)
                trk_peak = s.main_angle;
            case (trk_phase)
                jrpt_pkg::PH_STANDING:
                begin
                    trk_peak = '0;
                    cnt_one  = '0;
                    cnt_two  = '0;
                    if (s.main_angle > lim[jrpt_pkg::CFG_LOWER_THRESHOLD])
                    begin
                        trk_phase = jrpt_pkg::PH_RISING;
                        cap_begin = 1'b1;
                    end
                end
                jrpt_pkg::PH_RISING:
                begin
                    if (s.main_angle >= lim[jrpt_pkg::CFG_UPPER_THRESHOLD])
                        trk_phase = jrpt_pkg::PH_HOLDING;
                    else if (s.main_angle <= lim[jrpt_pkg::CFG_LOWER_THRESHOLD])
                        trk_phase = jrpt_pkg::PH_STANDING;
                end
                jrpt_pkg::PH_HOLDING:
                begin
                    if (s.main_angle < lim[jrpt_pkg::CFG_UPPER_THRESHOLD])
                        trk_phase = jrpt_pkg::PH_FALLING;
                end
                default:
                begin
                    if (s.main_angle <= lim[jrpt_pkg::CFG_LOWER_THRESHOLD])
                    begin
                        trk_phase = jrpt_pkg::PH_STANDING;
                        cap_end   = 1'b1;
                    end
                end
            endcase
        end
        r.phase         = trk_phase;
        r.peak_angle    = trk_peak;
        r.fail_total    = jrpt_pkg::TOTAL_W'(cnt_one) + jrpt_pkg::TOTAL_W'(cnt_two);
        r.warning       = warn;
        r.capture_begin = cap_begin;
        r.capture_end   = cap_end;
        r.started       = trk_started;
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result side: check each transaction, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result transaction with no sample waiting");
                    mismatches++;
                end
                else
                begin
                    jrpt_pkg::out_t want;
                    want = expected_reports.pop_front();
                    check_field("phase", want.phase, out_data.phase);
                    check_field("peak_angle", want.peak_angle, out_data.peak_angle);
                    check_field("fail_total", want.fail_total, out_data.fail_total);
                    check_field("warning", want.warning, out_data.warning);
                    check_field("capture_begin", want.capture_begin,
                                out_data.capture_begin);
                    check_field("capture_end", want.capture_end, out_data.capture_end);
                    check_field("started", want.started, out_data.started);
                end
                rx_hold = draw_wait(rx_calm);
            end
            else if (rx_hold > 0)
                rx_hold--;
            out_stall <= (rx_hold > 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL joint_rep_phase_tracker");
            $finish;
        end
    end

    task automatic send_sample(input jrpt_pkg::in_t s);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
        expected_reports.push_back(track_step(s));
        sent_count++;
    endtask

    // hold off the sender until every outstanding result is back
    task automatic settle_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [jrpt_pkg::CFG_IDX_W-1:0] idx,
                             input jrpt_pkg::angle_t val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx <= jrpt_pkg::CFG_SECOND_WINDOW_HIGH)
            lim[idx] = val;
    endtask

    task automatic write_all(input int lower, input int upper, input int w1_lo,
                             input int w1_hi, input int w2_lo, input int w2_hi);
        write_reg(jrpt_pkg::CFG_LOWER_THRESHOLD, clamp_angle(lower));
        write_reg(jrpt_pkg::CFG_UPPER_THRESHOLD, clamp_angle(upper));
        write_reg(jrpt_pkg::CFG_FIRST_WINDOW_LOW, clamp_angle(w1_lo));
        write_reg(jrpt_pkg::CFG_FIRST_WINDOW_HIGH, clamp_angle(w1_hi));
        write_reg(jrpt_pkg::CFG_SECOND_WINDOW_LOW, clamp_angle(w2_lo));
        write_reg(jrpt_pkg::CFG_SECOND_WINDOW_HIGH, clamp_angle(w2_hi));
    endtask

    function automatic jrpt_pkg::in_t rep_sample(int m);
        return make_sample(m + rand_between(-20, 20),
                           near_window(lim[jrpt_pkg::CFG_FIRST_WINDOW_LOW],
                                       lim[jrpt_pkg::CFG_FIRST_WINDOW_HIGH]),
                           near_window(lim[jrpt_pkg::CFG_SECOND_WINDOW_LOW],
                                       lim[jrpt_pkg::CFG_SECOND_WINDOW_HIGH]));
    endfunction

    // one repetition: climb past the upper threshold, hold, drop below the lower one
    task automatic send_rep();
        int lo_level;
        int hi_level;
        int n_up;
        int n_hold;
        int n_down;
        int i;
        lo_level = int'(lim[jrpt_pkg::CFG_LOWER_THRESHOLD]) - int'($urandom_range(300));
        hi_level = int'(lim[jrpt_pkg::CFG_UPPER_THRESHOLD]) + int'($urandom_range(300));
        n_up     = rand_between(1, 8);
        n_hold   = rand_between(0, 4);
        n_down   = rand_between(1, 8);
        for (i = 1; i <= n_up; i++)
            send_sample(rep_sample(lo_level + (hi_level - lo_level) * i / n_up));
        for (i = 0; i < n_hold; i++)
            send_sample(rep_sample(hi_level));
        for (i = 1; i <= n_down; i++)
            send_sample(rep_sample(hi_level - (hi_level - lo_level) * i / n_down));
    endtask

    task automatic test_idle_until_positive();
        int steps [4][3] = '{'{0, -1800, 1800}, '{-1800, 1800, -1800},
                             '{-1, 0, 0}, '{0, 700, 800}};
        foreach (steps[i])
            send_sample(make_sample(steps[i][0], steps[i][1], steps[i][2]));
    endtask

    // default registers: one aborted start, one full repetition
    task automatic test_full_repetition();
        int steps [12][3] = '{'{1, 0, 0}, '{300, 850, 900}, '{301, 700, 1100},
                              '{500, 699, 1101}, '{300, 1000, 800}, '{1800, 1001, 799},
                              '{900, 850, 950}, '{1800, -1800, -1800}, '{899, 850, 950},
                              '{900, 850, 950}, '{300, 850, 950}, '{-1800, 1800, 1800}};
        foreach (steps[i])
            send_sample(make_sample(steps[i][0], steps[i][1], steps[i][2]));
    endtask

    task automatic test_register_extremes();
        settle_outputs();
        // widest thresholds, crossed windows flag every sample
        write_all(-1800, 1800, 1800, -1800, 1800, -1800);
        write_reg(CFG_SPARE_LOW, clamp_angle(0));
        write_reg(CFG_SPARE_HIGH, clamp_angle(-1));
        send_sample(make_sample(-1799, 900, 950));
        send_sample(make_sample(1800, 1800, -1800));
        send_sample(make_sample(1799, -1800, 1800));
        send_sample(make_sample(-1800, 0, 0));
        send_sample(make_sample(-1800, 0, 0));
        settle_outputs();
        // thresholds reversed
        write_reg(jrpt_pkg::CFG_LOWER_THRESHOLD, clamp_angle(1800));
        write_reg(jrpt_pkg::CFG_UPPER_THRESHOLD, clamp_angle(-1800));
        send_sample(make_sample(1800, 0, 0));
        settle_outputs();
        write_reg(jrpt_pkg::CFG_LOWER_THRESHOLD, clamp_angle(1799));
        send_sample(make_sample(1800, 0, 0));
        send_sample(make_sample(-1800, 0, 0));
        send_sample(make_sample(-1800, 0, 0));
    endtask

    // park in rising with both aux angles out; both counters climb every sample
    task automatic test_parked_rising();
        settle_outputs();
        write_all(300, 900, 700, 1000, 800, 1100);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        send_sample(make_sample(-1800, 850, 950));
        send_sample(make_sample(-1800, 850, 950));
        send_sample(make_sample(500, 0, 0));
        for (int i = 0; i < PARK_ITEMS; i++)
            send_sample(make_sample(rand_between(301, 899), rand_between(-1800, 699),
                                    rand_between(1101, 1800)));
        send_sample(make_sample(0, 850, 950));
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_random_sessions();
        int start;
        int lower;
        int w1_lo;
        int w2_lo;
        int pick;
        for (int sess = 0; sess < NUM_SESSIONS; sess++)
        begin
            settle_outputs();
            if (sess == 0)
                write_all(-1800, 1800, -1800, 1800, -1800, 1800);
            else if (sess == 1)
                write_all(jrpt_pkg::RST_LOWER_THRESHOLD,
                          jrpt_pkg::RST_UPPER_THRESHOLD,
                          jrpt_pkg::RST_FIRST_WINDOW_LOW,
                          jrpt_pkg::RST_FIRST_WINDOW_HIGH,
                          jrpt_pkg::RST_SECOND_WINDOW_LOW,
                          jrpt_pkg::RST_SECOND_WINDOW_HIGH);
            else
            begin
                lower = rand_between(-600, 900);
                w1_lo = rand_between(-1800, 1500);
                w2_lo = rand_between(-1800, 1500);
                write_all(lower, lower + rand_between(100, 900), w1_lo,
                          ($urandom_range(5) == 0) ? w1_lo - rand_between(1, 300)
                                                   : w1_lo + rand_between(0, 600),
                          w2_lo,
                          ($urandom_range(5) == 0) ? w2_lo - rand_between(1, 300)
                                                   : w2_lo + rand_between(0, 600));
            end
            tx_calm = ($urandom_range(3) == 0);
            rx_calm = ($urandom_range(3) == 0);
            start   = sent_count;
            while (sent_count - start < SESSION_ITEMS)
            begin
                pick = $urandom_range(19);
                if (pick < 15)
                    send_rep();
                else if (pick < 19)
                    send_sample(make_sample(rand_between(-1800, 1800),
                                            rand_between(-1800, 1800),
                                            rand_between(-1800, 1800)));
                else
                    settle_outputs();
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_until_positive();
        test_full_repetition();
        test_register_extremes();
        test_parked_rising();
        test_random_sessions();
        settle_outputs();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS joint_rep_phase_tracker");
        else
            $display("FAIL joint_rep_phase_tracker");
        $finish;
    end

endmodule

FILE: files.f
design/jrpt_pkg.sv
design/jrpt_cfg_regs.sv
design/jrpt_core.sv
design/joint_rep_phase_tracker.sv
design/jrpt_checker.sv
test/joint_rep_phase_tracker_test.sv
